FILE: rtl/itaf_pkg.sv
// Shared types, codes and constants for the integer to ASCII formatter.
// Holds the queue word layout, the back-end state encoding and the digit table.
// No dependencies.
package itaf_pkg;

  // Value width and digit storage (octal needs the most digits)
  localparam int unsigned VAL_W         = 64;
  localparam int unsigned NDIG          = 22;
  localparam int unsigned NDIG_W        = $clog2(NDIG + 1);
  localparam int unsigned CONV_W        = $clog2(VAL_W);
  localparam int unsigned FW_W          = 7;
  localparam int unsigned MAX_WIDTH_DEF = 64;
  localparam int unsigned QDEPTH        = 2;

  // ASCII codes
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_UX    = 8'h58;
  localparam logic [7:0] CH_LX    = 8'h78;

  typedef enum logic [2:0] {
    CMD_SDEC = 3'd0,
    CMD_UDEC = 3'd1,
    CMD_OCT  = 3'd2,
    CMD_HEXL = 3'd3,
    CMD_HEXU = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    SIZE_32 = 2'd0,
    SIZE_16 = 2'd1,
    SIZE_64 = 2'd2
  } size_mode_t;

  typedef enum logic [1:0] {
    RADIX_DEC = 2'd0,
    RADIX_OCT = 2'd1,
    RADIX_HEX = 2'd2
  } radix_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'd0,
    ST_CONV = 3'd1,
    ST_NORM = 3'd2,
    ST_PLAN = 3'd3,
    ST_EMIT = 3'd4
  } state_t;

  // One classified word as it travels from front to back
  typedef struct packed {
    logic [VAL_W-1:0]    mag;
    radix_t              radix;
    logic                upper;
    logic [1:0]          npre;
    logic [2:0][7:0]     pre;
    logic                left;
    logic                zero;
    logic [FW_W-1:0]     width;
  } itaf_item_t;

  // Map a digit value to its ASCII character
  function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
    logic [7:0] base;
    begin
      base = upper ? CH_UA : CH_LA;
      if (d < 4'd10) begin
        return CH_ZERO + 8'(d);
      end else begin
        return base + 8'(d) - 8'd10;
      end
    end
  endfunction

endpackage

FILE: rtl/integer_to_ascii_formatter_core.sv
// Top level of the integer to ASCII formatter: front end, queue and back end.
// Depends on itaf_pkg, itaf_front, itaf_queue and itaf_back.
//
// Formats one integer per input word as a printf-style field (signed or unsigned
// decimal, octal, lower or upper hex, with plus, blank, zero, alt and left flags and a
// minimum width) and sends it out one ASCII character per word, the last marked by
// out_last_char. Per field, the back end takes the word from the queue, converts a
// decimal value with the shift and add-3 converter (octal and hex skip it), strips
// leading zeros one digit at a time, lays out the field and then emits one character
// per cycle while the output is not stalled; the field holds max(width, length)
// characters, with width saturated at MAX_WIDTH. A two-word queue lets the input
// accept up to two further words while a field is being emitted. No clearing pass
// is needed after reset.
module integer_to_ascii_formatter_core #(
  parameter int unsigned MAX_WIDTH = itaf_pkg::MAX_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [63:0] in_value,
  input  logic [2:0]  in_cmd,
  input  logic [1:0]  in_size_mode,
  input  logic        in_flag_left,
  input  logic        in_flag_plus,
  input  logic        in_flag_blank,
  input  logic        in_flag_zero,
  input  logic        in_flag_alt,
  input  logic [6:0]  in_field_width,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_char,
  output logic        out_last_char
);
  import itaf_pkg::*;

  logic       q_full;
  logic       q_empty;
  logic       push;
  logic       pop;
  itaf_item_t push_item;
  itaf_item_t pop_item;

  itaf_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_value       (in_value),
    .in_cmd         (in_cmd),
    .in_size_mode   (in_size_mode),
    .in_flag_left   (in_flag_left),
    .in_flag_plus   (in_flag_plus),
    .in_flag_blank  (in_flag_blank),
    .in_flag_zero   (in_flag_zero),
    .in_flag_alt    (in_flag_alt),
    .in_field_width (in_field_width),
    .q_full         (q_full),
    .push           (push),
    .push_item      (push_item)
  );

  itaf_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .pop_item  (pop_item),
    .full      (q_full),
    .empty     (q_empty)
  );

  itaf_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_empty       (q_empty),
    .q_item        (pop_item),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_char      (out_char),
    .out_last_char (out_last_char)
  );

endmodule

FILE: rtl/itaf_front.sv
// Front end of the formatter: accepts input words and classifies them.
// Produces sign, magnitude, radix and prefix for the queue. Uses itaf_pkg.
module itaf_front #(
  parameter int unsigned MAX_WIDTH = itaf_pkg::MAX_WIDTH_DEF
) (
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [63:0]               in_value,
  input  logic [2:0]                in_cmd,
  input  logic [1:0]                in_size_mode,
  input  logic                      in_flag_left,
  input  logic                      in_flag_plus,
  input  logic                      in_flag_blank,
  input  logic                      in_flag_zero,
  input  logic                      in_flag_alt,
  input  logic [6:0]                in_field_width,
  input  logic                      q_full,
  output logic                      push,
  output itaf_pkg::itaf_item_t      push_item
);
  import itaf_pkg::*;

  localparam logic [FW_W:0] WMAX = (FW_W + 1)'(MAX_WIDTH);

  logic [VAL_W-1:0] masked;
  logic [VAL_W-1:0] mag;
  logic [7:0]       sign_ch;
  logic             has_sign;
  radix_t           radix;
  logic             upper;
  logic [1:0]       alt_n;
  logic [7:0]       alt_x;

  // Stall only on a full queue
  assign in_stall = q_full;
  assign push     = in_valid & ~q_full;

  // Cut the value to the selected size
  always_comb begin
    unique case (size_mode_t'(in_size_mode))
      SIZE_32: masked = {32'h0, in_value[31:0]};
      SIZE_16: masked = {48'h0, in_value[15:0]};
      default: masked = in_value;
    endcase
  end

  // Decode the conversion: radix, case and sign
  always_comb begin
    mag      = masked;
    radix    = RADIX_DEC;
    upper    = 1'b0;
    has_sign = in_flag_plus | in_flag_blank;
    sign_ch  = in_flag_plus ? CH_PLUS : CH_SPACE;
    unique case (cmd_t'(in_cmd))
      CMD_SDEC: begin
        if (masked[VAL_W-1]) begin
          mag      = VAL_W'(0) - masked;
          has_sign = 1'b1;
          sign_ch  = CH_MINUS;
        end
      end
      CMD_OCT:  radix = RADIX_OCT;
      CMD_HEXL: radix = RADIX_HEX;
      CMD_HEXU: begin
        radix = RADIX_HEX;
        upper = 1'b1;
      end
      default:  radix = RADIX_DEC;
    endcase
  end

  // Assemble the prefix and saturate the width
  always_comb begin
    alt_x = upper ? CH_UX : CH_LX;
    alt_n = 2'd0;
    if (in_flag_alt && radix == RADIX_OCT) begin
      alt_n = 2'd1;
    end else if (in_flag_alt && radix == RADIX_HEX) begin
      alt_n = 2'd2;
    end
    push_item.mag   = mag;
    push_item.radix = radix;
    push_item.upper = upper;
    push_item.left  = in_flag_left;
    push_item.zero  = in_flag_zero;
    if (has_sign) begin
      push_item.pre[0] = sign_ch;
      push_item.pre[1] = CH_ZERO;
      push_item.pre[2] = alt_x;
      push_item.npre   = alt_n + 2'd1;
    end else begin
      push_item.pre[0] = CH_ZERO;
      push_item.pre[1] = alt_x;
      push_item.pre[2] = CH_SPACE;
      push_item.npre   = alt_n;
    end
    if ({1'b0, in_field_width} > WMAX) begin
      push_item.width = WMAX[FW_W-1:0];
    end else begin
      push_item.width = in_field_width;
    end
  end

endmodule

FILE: rtl/itaf_queue.sv
// Two-entry queue that decouples the front end from the back end.
// Carries itaf_pkg::itaf_item_t words. Uses itaf_pkg.
module itaf_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  itaf_pkg::itaf_item_t  push_item,
  input  logic                  pop,
  output itaf_pkg::itaf_item_t  pop_item,
  output logic                  full,
  output logic                  empty
);
  import itaf_pkg::*;

  localparam int unsigned PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QDEPTH + 1);

  itaf_item_t       slot_r [QDEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign full     = (cnt_r == CNT_W'(QDEPTH));
  assign empty    = (cnt_r == '0);
  assign pop_item = slot_r[rd_ptr_r];

  // Advance pointers and fill count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Write the payload slot
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

FILE: rtl/itaf_back.sv
// Back end of the formatter: converts the magnitude to digits and emits characters.
// Shift-and-add-3 decimal conversion, leading zero strip, field layout, output register.
// Uses itaf_pkg.
module itaf_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_empty,
  input  itaf_pkg::itaf_item_t  q_item,
  output logic                  pop,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [7:0]            out_char,
  output logic                  out_last_char
);
  import itaf_pkg::*;

  state_t                  state_r, state_nxt;
  itaf_item_t              item_r, item_nxt;
  logic [NDIG-1:0][3:0]    dig_r, dig_nxt;
  logic [VAL_W-1:0]        bin_r, bin_nxt;
  logic [CONV_W-1:0]       step_r, step_nxt;
  logic [NDIG_W-1:0]       ndig_r, ndig_nxt;
  logic [FW_W-1:0]         b1_r, b1_nxt, b2_r, b2_nxt, b3_r, b3_nxt;
  logic [FW_W-1:0]         b4_r, b4_nxt, bend_r, bend_nxt;
  logic [FW_W-1:0]         pos_r, pos_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [7:0]              out_char_r, out_char_nxt;
  logic                    out_last_r, out_last_nxt;

  logic                    out_ld;
  logic                    top_zero;
  logic                    is_last;
  logic [NDIG-1:0][3:0]    corr;
  logic [NDIG*4+VAL_W:0]   sh;
  logic [NDIG-1:0][3:0]    load_dig;
  logic [NDIG*4-1:0]       mag_ext;
  logic [FW_W-1:0]         total;
  logic [FW_W-1:0]         pad;
  logic [1:0]              pre_idx;
  logic [7:0]              pre_ch;

  assign out_valid     = out_valid_r;
  assign out_char      = out_char_r;
  assign out_last_char = out_last_r;

  assign out_ld   = ~out_valid_r | ~out_stall;
  assign top_zero = (dig_r[NDIG-1] == 4'h0) && (ndig_r > NDIG_W'(1));
  assign is_last  = (pos_r == bend_r - FW_W'(1));
  assign pop      = (state_r == ST_IDLE) && !q_empty;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          state_nxt = (q_item.radix == RADIX_DEC) ? ST_CONV : ST_NORM;
        end
      end
      ST_CONV: begin
        if (step_r == CONV_W'(VAL_W - 1)) begin
          state_nxt = ST_NORM;
        end
      end
      ST_NORM: begin
        if (!top_zero) begin
          state_nxt = ST_PLAN;
        end
      end
      ST_PLAN: state_nxt = ST_EMIT;
      ST_EMIT: begin
        if (out_ld && is_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Correct each BCD digit before the shift
  always_comb begin
    for (int i = 0; i < NDIG; i++) begin
      corr[i] = (dig_r[i] >= 4'd5) ? dig_r[i] + 4'd3 : dig_r[i];
    end
    sh = {corr, bin_r, 1'b0};
  end

  // Split a binary magnitude straight into octal or hex digits
  always_comb begin
    mag_ext = {(NDIG*4-VAL_W)'(0), q_item.mag};
    for (int i = 0; i < NDIG; i++) begin
      if (q_item.radix == RADIX_OCT) begin
        load_dig[i] = {1'b0, mag_ext[3*i +: 3]};
      end else begin
        load_dig[i] = mag_ext[4*i +: 4];
      end
    end
  end

  // Field layout for the current word
  always_comb begin
    total = FW_W'(item_r.npre) + FW_W'(ndig_r);
    pad   = (item_r.width > total) ? item_r.width - total : '0;
  end

  // Pick the prefix character at the current position
  always_comb begin
    pre_idx = 2'(pos_r - b1_r);
    case (pre_idx)
      2'd0:    pre_ch = item_r.pre[0];
      2'd1:    pre_ch = item_r.pre[1];
      default: pre_ch = item_r.pre[2];
    endcase
  end

  // Datapath and output register
  always_comb begin
    item_nxt      = item_r;
    dig_nxt       = dig_r;
    bin_nxt       = bin_r;
    step_nxt      = step_r;
    ndig_nxt      = ndig_r;
    b1_nxt        = b1_r;
    b2_nxt        = b2_r;
    b3_nxt        = b3_r;
    b4_nxt        = b4_r;
    bend_nxt      = bend_r;
    pos_nxt       = pos_r;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    out_valid_nxt = out_valid_r & out_stall;
    unique case (state_r)
      ST_IDLE: begin
        item_nxt = q_item;
        bin_nxt  = q_item.mag;
        step_nxt = '0;
        ndig_nxt = NDIG_W'(NDIG);
        dig_nxt  = (q_item.radix == RADIX_DEC) ? '0 : load_dig;
      end
      ST_CONV: begin
        {dig_nxt, bin_nxt} = sh[NDIG*4+VAL_W-1:0];
        step_nxt = step_r + CONV_W'(1);
      end
      ST_NORM: begin
        // Drop one leading zero digit, keep at least one
        if (top_zero) begin
          dig_nxt  = {dig_r[NDIG-2:0], 4'h0};
          ndig_nxt = ndig_r - NDIG_W'(1);
        end
      end
      ST_PLAN: begin
        b1_nxt   = (!item_r.left && !item_r.zero) ? pad : '0;
        b2_nxt   = b1_nxt + FW_W'(item_r.npre);
        b3_nxt   = b2_nxt + ((!item_r.left && item_r.zero) ? pad : '0);
        b4_nxt   = b3_nxt + FW_W'(ndig_r);
        bend_nxt = b4_nxt + (item_r.left ? pad : '0);
        pos_nxt  = '0;
      end
      ST_EMIT: begin
        if (out_ld) begin
          out_valid_nxt = 1'b1;
          out_last_nxt  = is_last;
          pos_nxt       = pos_r + FW_W'(1);
          if (pos_r < b1_r) begin
            out_char_nxt = CH_SPACE;
          end else if (pos_r < b2_r) begin
            out_char_nxt = pre_ch;
          end else if (pos_r < b3_r) begin
            out_char_nxt = CH_ZERO;
          end else if (pos_r < b4_r) begin
            out_char_nxt = digit_char(dig_r[NDIG-1], item_r.upper);
            dig_nxt      = {dig_r[NDIG-2:0], 4'h0};
          end else begin
            out_char_nxt = CH_SPACE;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Hold payload and work registers
  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    dig_r      <= dig_nxt;
    bin_r      <= bin_nxt;
    step_r     <= step_nxt;
    ndig_r     <= ndig_nxt;
    b1_r       <= b1_nxt;
    b2_r       <= b2_nxt;
    b3_r       <= b3_nxt;
    b4_r       <= b4_nxt;
    bend_r     <= bend_nxt;
    pos_r      <= pos_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

endmodule

FILE: rtl/itaf_checker.sv
// Port-level checks for integer_to_ascii_formatter_core, bound to the top level.
// Depends only on the top level's ports.
module itaf_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_char,
  input logic       out_last_char
);

  // Reset empties the output register
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // A stalled character holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_char) && $stable(out_last_char))
    else $error("stalled output changed");

  // A field ends on a digit or a space, never on a prefix character
  a_last_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_char |->
      (out_char >= 8'h30 && out_char <= 8'h39) ||
      (out_char >= 8'h61 && out_char <= 8'h66) ||
      (out_char >= 8'h41 && out_char <= 8'h46) ||
      (out_char == 8'h20))
    else $error("field ends on a prefix character");

  // Nothing leaves the block until a word has gone in after reset
  a_no_early_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid ##1 (!out_valid || $past(in_valid && !in_stall, 1) ||
      $past(out_valid, 1)))
    else $error("output without input");

endmodule

bind integer_to_ascii_formatter_core itaf_checker u_itaf_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_char      (out_char),
  .out_last_char (out_last_char)
);

FILE: bench/itaf_field_checker.sv
`timescale 1ns / 100ps
// Checker for the integer to ASCII formatter: watches both channels, predicts each field.
// Compares every character word with its expected character and end-of-field mark.
// Depends on itaf_pkg.
module itaf_field_checker #(
  parameter int unsigned MAX_W = itaf_pkg::MAX_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [63:0] in_value,
  input  logic [2:0]  in_cmd,
  input  logic [1:0]  in_size_mode,
  input  logic        in_flag_left,
  input  logic        in_flag_plus,
  input  logic        in_flag_blank,
  input  logic        in_flag_zero,
  input  logic        in_flag_alt,
  input  logic [6:0]  in_field_width,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [7:0]  out_char,
  input  logic        out_last_char,
  output int unsigned fail_count,
  output int unsigned pending,
  output int unsigned chars_checked
);
  import itaf_pkg::*;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } char_word_t;

  // Characters still owed by the block, oldest first
  char_word_t  owed_chars[$];
  int unsigned mismatches = 0;
  int unsigned seen_chars = 0;

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    mismatches++;
  endtask

  // Lay out one printf-style field and queue its characters
  task automatic predict_field(input logic [63:0] value, input logic [2:0] cmd,
                               input logic [1:0] size, input logic left,
                               input logic plus, input logic blank, input logic zero,
                               input logic alt, input logic [6:0] fw);
    logic [63:0] mag;
    logic [63:0] d;
    logic [7:0]  sign_ch;
    logic        has_sign;
    logic        upper;
    logic [7:0]  pre [0:2];
    logic [7:0]  dig [0:63];
    logic [7:0]  text [0:63];
    int unsigned radix, width, npre, ndig, total, pad, k, i;
    char_word_t  w;
    begin
      width = (fw > MAX_W) ? MAX_W : fw;
      if (size == SIZE_32) mag = value & 64'h0000_0000_FFFF_FFFF;
      else if (size == SIZE_16) mag = value & 64'h0000_0000_0000_FFFF;
      else mag = value;

      has_sign = plus | blank;
      sign_ch = plus ? CH_PLUS : CH_SPACE;
      upper = 1'b0;
      radix = 10;
      if (cmd == CMD_SDEC) begin
        if (mag[63]) begin
          has_sign = 1'b1;
          sign_ch = CH_MINUS;
          mag = 64'd0 - mag;
        end
      end else if (cmd == CMD_OCT) begin
        radix = 8;
      end else if (cmd == CMD_HEXL) begin
        radix = 16;
      end else if (cmd == CMD_HEXU) begin
        radix = 16;
        upper = 1'b1;
      end

      // Digits come out least significant first
      ndig = 0;
      do begin
        d = mag % radix;
        if (d < 10) dig[ndig] = CH_ZERO + d[7:0];
        else dig[ndig] = (upper ? CH_UA : CH_LA) + d[7:0] - 8'd10;
        ndig++;
        mag = mag / radix;
      end while (mag != 0 && ndig < 64);

      npre = 0;
      if (has_sign) begin
        pre[npre] = sign_ch;
        npre++;
      end
      if (alt && radix == 8) begin
        pre[npre] = CH_ZERO;
        npre++;
      end else if (alt && radix == 16) begin
        pre[npre] = CH_ZERO;
        pre[npre + 1] = upper ? CH_UX : CH_LX;
        npre += 2;
      end

      total = npre + ndig;
      pad = (width > total) ? width - total : 0;
      k = 0;
      if (!left && !zero) begin
        for (i = 0; i < pad; i++) begin
          text[k] = CH_SPACE;
          k++;
        end
      end
      for (i = 0; i < npre; i++) begin
        text[k] = pre[i];
        k++;
      end
      if (!left && zero) begin
        for (i = 0; i < pad; i++) begin
          text[k] = CH_ZERO;
          k++;
        end
      end
      for (i = ndig; i > 0; i--) begin
        text[k] = dig[i - 1];
        k++;
      end
      if (left) begin
        for (i = 0; i < pad; i++) begin
          text[k] = CH_SPACE;
          k++;
        end
      end

      for (i = 0; i < k; i++) begin
        w.ch = text[i];
        w.last = (i == k - 1);
        owed_chars.push_back(w);
      end
    end
  endtask

  // Retire an output word against the oldest owed character, then queue new fields
  always @(posedge clk) begin
    char_word_t w;
    if (!rst_n) begin
      owed_chars.delete();
      pending <= 0;
      chars_checked <= 0;
      fail_count <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (owed_chars.size() == 0) begin
          report_mismatch($sformatf("unexpected character %h, last %b", out_char,
                                    out_last_char));
        end else begin
          w = owed_chars.pop_front();
          if (out_char !== w.ch)
            report_mismatch($sformatf("character %0d: expected %h, got %h",
                                      seen_chars, w.ch, out_char));
          if (out_last_char !== w.last)
            report_mismatch($sformatf("character %0d end mark: expected %b, got %b",
                                      seen_chars, w.last, out_last_char));
        end
        seen_chars++;
      end
      if (in_valid && !in_stall)
        predict_field(in_value, in_cmd, in_size_mode, in_flag_left, in_flag_plus,
                      in_flag_blank, in_flag_zero, in_flag_alt, in_field_width);
      pending <= owed_chars.size();
      chars_checked <= seen_chars;
      fail_count <= mismatches;
    end
  end

endmodule

FILE: bench/tb.sv
`timescale 1ns / 100ps
// Top of the formatter testbench: clock, reset, field stimulus, output stalls and verdict.
// Depends on itaf_pkg, integer_to_ascii_formatter_core and itaf_field_checker.
module tb;
  import itaf_pkg::*;

  localparam int unsigned MAX_W         = MAX_WIDTH_DEF;
  localparam int unsigned RANDOM_FIELDS = 157;
  localparam int unsigned IDLE_LIMIT    = 5000;
  localparam int unsigned HOLD_CYCLES   = 600;
  localparam int unsigned DRAIN_CYCLES  = 200;
  localparam int unsigned HOLD_START    = 40;
  localparam int unsigned HOLD_BURST    = 12;
  localparam logic [2:0]  CMD_SPARE_LO  = 3'd5;
  localparam logic [2:0]  CMD_SPARE_HI  = 3'd7;
  localparam logic [1:0]  SIZE_SPARE    = 2'd3;
  localparam logic [6:0]  FW_MAX        = 7'(MAX_W);

  typedef struct packed {
    logic [63:0] value;
    logic [2:0]  cmd;
    logic [1:0]  size;
    logic        left;
    logic        plus;
    logic        blank;
    logic        zero;
    logic        alt;
    logic [6:0]  width;
  } field_req_t;

  localparam int unsigned REQ_W = $bits(field_req_t);

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [63:0] in_value;
  logic [2:0]  in_cmd;
  logic [1:0]  in_size_mode;
  logic        in_flag_left;
  logic        in_flag_plus;
  logic        in_flag_blank;
  logic        in_flag_zero;
  logic        in_flag_alt;
  logic [6:0]  in_field_width;
  logic        out_valid;
  logic        out_stall;
  logic [7:0]  out_char;
  logic        out_last_char;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned chars_checked;
  int unsigned fields_sent = 0;
  int unsigned idle_cycles = 0;
  logic        hold_go;
  logic        quiet;

  integer_to_ascii_formatter_core #(.MAX_WIDTH(MAX_W)) u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_value(in_value), .in_cmd(in_cmd), .in_size_mode(in_size_mode),
    .in_flag_left(in_flag_left), .in_flag_plus(in_flag_plus),
    .in_flag_blank(in_flag_blank), .in_flag_zero(in_flag_zero),
    .in_flag_alt(in_flag_alt), .in_field_width(in_field_width),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_char(out_char), .out_last_char(out_last_char)
  );

  itaf_field_checker #(.MAX_W(MAX_W)) u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_value(in_value), .in_cmd(in_cmd), .in_size_mode(in_size_mode),
    .in_flag_left(in_flag_left), .in_flag_plus(in_flag_plus),
    .in_flag_blank(in_flag_blank), .in_flag_zero(in_flag_zero),
    .in_flag_alt(in_flag_alt), .in_field_width(in_field_width),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_char(out_char), .out_last_char(out_last_char),
    .fail_count(fail_count), .pending(pending), .chars_checked(chars_checked)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // End the run when neither channel moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no word moved for %0d cycles, %0d characters owed",
               idle_cycles, pending);
      $display("FAIL integer_to_ascii_formatter_core");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Stall the output in random bursts; hold it off once for a long stretch
  initial begin : out_stall_gen
    int unsigned r;
    int unsigned n;
    logic        hold_done;
    hold_done = 1'b0;
    out_stall = 1'b0;
    forever begin
      if (hold_go && !hold_done) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 10) begin
          out_stall <= 1'b0;
          n = $urandom_range(30, 120);
        end else if (r < 55) begin
          out_stall <= 1'b0;
          n = $urandom_range(1, 4);
        end else if (r < 93) begin
          out_stall <= 1'b1;
          n = $urandom_range(1, 3);
        end else begin
          out_stall <= 1'b1;
          n = $urandom_range(10, 50);
        end
        repeat (n) @(posedge clk);
      end
    end
  end

  function automatic field_req_t make_field(input logic [63:0] v, input logic [2:0] c,
                                            input logic [1:0] s, input logic l,
                                            input logic p, input logic b, input logic z,
                                            input logic a, input logic [6:0] w);
    field_req_t f;
    f.value = v;
    f.cmd = c;
    f.size = s;
    f.left = l;
    f.plus = p;
    f.blank = b;
    f.zero = z;
    f.alt = a;
    f.width = w;
    return f;
  endfunction

  // Mostly short gaps, a few long ones, none during quiet stretches
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet || r < 45) return 0;
    if (r < 80) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(40, 120);
  endfunction

  function automatic field_req_t random_field();
    field_req_t  f;
    int unsigned r;
    f = REQ_W'({$urandom, $urandom, $urandom});
    case ($urandom_range(0, 5))
      0: f.value = {$urandom, $urandom};
      1: f.value = 64'($urandom_range(0, 1000));
      2: f.value = {$urandom, $urandom} >> $urandom_range(0, 63);
      3: f.value = {1'b1, 31'($urandom), $urandom};
      4: begin
        case ($urandom_range(0, 4))
          0: f.value = 64'd0;
          1: f.value = '1;
          2: f.value = 64'h8000_0000_0000_0000;
          3: f.value = 64'h7FFF_FFFF_FFFF_FFFF;
          default: f.value = 64'h0000_0000_FFFF_FFFF;
        endcase
      end
      default: f.value = {$urandom, $urandom} & 64'hFFFF;
    endcase
    if ($urandom_range(0, 15) == 0) f.cmd = 3'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
    else f.cmd = 3'($urandom_range(CMD_SDEC, CMD_HEXU));
    if ($urandom_range(0, 15) == 0) f.size = SIZE_SPARE;
    else f.size = 2'($urandom_range(SIZE_32, SIZE_64));
    r = $urandom_range(0, 99);
    if (r < 70) f.width = 7'($urandom_range(0, 24));
    else if (r < 90) f.width = 7'($urandom_range(25, MAX_W));
    else f.width = 7'($urandom_range(MAX_W + 1, 127));
    return f;
  endfunction

  // Offer one field word and hold it until it is taken
  task automatic send_field(input field_req_t f, input int unsigned gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_value <= f.value;
    in_cmd <= f.cmd;
    in_size_mode <= f.size;
    in_flag_left <= f.left;
    in_flag_plus <= f.plus;
    in_flag_blank <= f.blank;
    in_flag_zero <= f.zero;
    in_flag_alt <= f.alt;
    in_field_width <= f.width;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    fields_sent++;
  endtask

  initial begin : stimulus
    int unsigned i;
    int unsigned directed_fields;
    rst_n = 1'b0;
    hold_go = 1'b0;
    quiet = 1'b0;
    in_valid = 1'b0;
    in_value = '0;
    in_cmd = CMD_SDEC;
    in_size_mode = SIZE_32;
    in_flag_left = 1'b0;
    in_flag_plus = 1'b0;
    in_flag_blank = 1'b0;
    in_flag_zero = 1'b0;
    in_flag_alt = 1'b0;
    in_field_width = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: extremes, every conversion, sign and prefix rules, width limits
    send_field(make_field(64'd0, CMD_SDEC, SIZE_32, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 7'd0),
               pick_gap());
    send_field(make_field('1, CMD_SDEC, SIZE_64, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 7'd0),
               pick_gap());
    send_field(make_field(64'h8000_0000_0000_0000, CMD_SDEC, SIZE_64, 1'b0, 1'b1, 1'b0,
                          1'b0, 1'b0, 7'd0), pick_gap());
    send_field(make_field('1, CMD_UDEC, SIZE_64, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 7'd0),
               pick_gap());
    send_field(make_field('1, CMD_OCT, SIZE_64, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 7'd0),
               pick_gap());
    send_field(make_field(64'd0, CMD_HEXL, SIZE_32, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 7'd0),
               pick_gap());
    send_field(make_field(64'd0, CMD_OCT, SIZE_32, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 7'd0),
               pick_gap());
    send_field(make_field(64'hDEAD_BEEF, CMD_HEXU, SIZE_32, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1,
                          7'd20), pick_gap());
    send_field(make_field(64'hABC, CMD_HEXL, SIZE_16, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 7'd0),
               pick_gap());
    send_field(make_field(64'd42, CMD_SDEC, SIZE_32, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 7'd5),
               pick_gap());
    send_field(make_field(-64'sd12345, CMD_SDEC, SIZE_64, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0,
                          7'd30), pick_gap());
    send_field(make_field(-64'sd7, CMD_SDEC, SIZE_64, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0,
                          FW_MAX), pick_gap());
    send_field(make_field(64'd99, CMD_UDEC, SIZE_32, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0,
                          7'd127), pick_gap());
    send_field(make_field('1, CMD_OCT, SIZE_64, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, FW_MAX),
               pick_gap());
    send_field(make_field(64'hFFFF_0000_1234_5678, CMD_SPARE_LO, SIZE_64, 1'b0, 1'b0,
                          1'b0, 1'b0, 1'b1, 7'd0), pick_gap());
    send_field(make_field(64'd1, 3'd6, SIZE_32, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 7'd3),
               pick_gap());
    send_field(make_field(64'hFEDC_BA98_7654_3210, CMD_SPARE_HI, SIZE_SPARE, 1'b0, 1'b0,
                          1'b0, 1'b0, 1'b0, 7'd0), pick_gap());
    send_field(make_field('1, CMD_UDEC, SIZE_16, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 7'd0),
               pick_gap());
    send_field(make_field('1, CMD_SDEC, SIZE_32, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 7'd0),
               pick_gap());
    send_field(make_field(64'h8000_0000_0000_00FF, CMD_HEXL, SIZE_SPARE, 1'b0, 1'b0, 1'b0,
                          1'b0, 1'b1, 7'd0), pick_gap());
    send_field(make_field(64'd255, CMD_HEXU, SIZE_32, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 7'd12),
               pick_gap());
    send_field(make_field(64'd12345, CMD_UDEC, SIZE_32, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0,
                          7'd5), pick_gap());
    send_field(make_field(64'hFFFF_FFFF, CMD_UDEC, SIZE_64, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
                          7'd1), pick_gap());
    directed_fields = fields_sent;

    // Random fields; back-to-back words while the output is held off
    for (i = 0; i < RANDOM_FIELDS; i++) begin
      if (i % 16 == 0) quiet = ($urandom_range(0, 3) == 0);
      if (i == HOLD_START) hold_go <= 1'b1;
      send_field(random_field(),
                 (i >= HOLD_START && i < HOLD_START + HOLD_BURST) ? 0 : pick_gap());
    end
    in_valid <= 1'b0;

    // Drain owed characters, then watch for strays
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d fields (%0d directed) over all conversions, sizes, flags and widths;",
             fields_sent, directed_fields);
    $display("checked %0d characters, with one output hold-off of %0d cycles.",
             chars_checked, HOLD_CYCLES);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS integer_to_ascii_formatter_core");
    end else begin
      $display("FAIL integer_to_ascii_formatter_core");
    end
    $finish;
  end

endmodule
